// File: design/palette_builder_quantizer_core_macros.svh
// assertion macros for the palette builder checker
`ifndef PALETTE_BUILDER_QUANTIZER_CORE_MACROS_SVH
`define PALETTE_BUILDER_QUANTIZER_CORE_MACROS_SVH

// concurrent assertion on an explicit clock and active-low reset
`define PBQ_ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("palette builder assertion failed");

// concurrent assertion on the block clock and reset
`define PBQ_ASSERT(lbl, prop) \
  `PBQ_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

// File: design/pbq_pkg.sv
// package with types and constants of the palette builder
`default_nettype none

package pbq_pkg;

  localparam int unsigned PaletteSizeDef = 256;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_pixel;
  } pixel_t;

  typedef struct packed {
    logic [7:0] palette_index;
    logic       added_entry;
    logic       palette_full;
    logic       last_out;
  } result_t;

  typedef enum logic [1:0] {
    StIdle,
    StSearch,
    StResp
  } state_e;

endpackage

`default_nettype wire

// File: design/pbq_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module pbq_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: design/palette_builder_quantizer_core.sv
// A black pixel's result goes straight to the response state without a search; any other
// pixel searches the filled entries (at most PaletteSize-2), as one comparator walks the
// palette ram a read a cycle. A new request is taken the cycle after the result is
// latched, so only one request is in flight at a time.
// Reset is asynchronous and active low; no clearing pass: a fill counter marks written
// entries and entry 0 is black by construction, so ram contents need no reset.
`default_nettype none

module palette_builder_quantizer_core
  import pbq_pkg::*;
#(
  parameter int unsigned PaletteSize = PaletteSizeDef
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire pixel_t  in_data_i,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output result_t      out_data_o
);

  localparam int unsigned IdxW = $clog2(PaletteSize);
  localparam int unsigned CntW = $clog2(PaletteSize + 1);

  state_e            state_q, state_d;
  pixel_t            pix_q, pix_d;
  logic [IdxW-1:0]   addr_q, addr_d;
  logic              pend_q, pend_d;
  logic [IdxW-1:0]   pend_idx_q, pend_idx_d;
  logic [IdxW-1:0]   end_q, end_d;
  logic [CntW-1:0]   free_slot_q, free_slot_d;
  result_t           res_q, res_d;
  result_t           out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic              ram_we;
  logic [IdxW-1:0]   ram_waddr;
  logic [23:0]       ram_wdata;
  logic [IdxW-1:0]   ram_raddr;
  logic [23:0]       ram_rdata;

  logic [23:0]       colour_in;
  logic [23:0]       colour_q;
  logic              out_free;
  logic              match;
  logic              miss;
  logic              slot_left;

  assign colour_in = {in_data_i.red, in_data_i.green, in_data_i.blue};
  assign colour_q  = {pix_q.red, pix_q.green, pix_q.blue};
  assign out_free  = !out_valid_q || out_ready_i;
  assign match     = pend_q && (ram_rdata == colour_q);
  // nothing searched yet only when the table holds entry 0 alone
  assign miss      = pend_q ? (!match && (pend_idx_q == end_q)) : (addr_q > end_q);
  assign slot_left = free_slot_q < CntW'(PaletteSize);

  pbq_ram #(
    .Width(24),
    .Depth(PaletteSize)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // next state and datapath
  always_comb begin
    state_d     = state_q;
    pix_d       = pix_q;
    addr_d      = addr_q;
    pend_d      = 1'b0;
    pend_idx_d  = pend_idx_q;
    end_d       = end_q;
    res_d       = res_q;
    free_slot_d = free_slot_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          pix_d  = in_data_i;
          addr_d = IdxW'(1);
          // search stops at the last filled entry, never at the top entry
          if (free_slot_q == CntW'(PaletteSize)) begin
            end_d = IdxW'(PaletteSize - 2);
          end else begin
            end_d = IdxW'(free_slot_q - CntW'(1));
          end
          if (colour_in == 24'd0) begin
            res_d = '{palette_index: 8'd0, added_entry: 1'b0, palette_full: 1'b0,
                      last_out: in_data_i.last_pixel};
            state_d = StResp;
          end else begin
            state_d = StSearch;
          end
        end
      end
      StSearch: begin
        if (addr_q <= end_q) begin
          pend_d     = 1'b1;
          pend_idx_d = addr_q;
          addr_d     = addr_q + IdxW'(1);
        end
        if (match) begin
          res_d = '{palette_index: 8'(pend_idx_q), added_entry: 1'b0, palette_full: 1'b0,
                    last_out: pix_q.last_pixel};
          pend_d  = 1'b0;
          state_d = StResp;
        end else if (miss) begin
          if (slot_left) begin
            res_d = '{palette_index: 8'(free_slot_q[IdxW-1:0]), added_entry: 1'b1,
                      palette_full: 1'b0, last_out: pix_q.last_pixel};
          end else begin
            res_d = '{palette_index: 8'd0, added_entry: 1'b0, palette_full: 1'b1,
                      last_out: pix_q.last_pixel};
          end
          pend_d  = 1'b0;
          state_d = StResp;
        end
      end
      StResp: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          if (res_q.added_entry) begin
            free_slot_d = free_slot_q + CntW'(1);
          end
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // outputs and ram controls
  always_comb begin
    in_ready_o  = (state_q == StIdle);
    ram_raddr   = addr_q;
    ram_we      = (state_q == StResp) && out_free && res_q.added_entry;
    ram_waddr   = free_slot_q[IdxW-1:0];
    ram_wdata   = colour_q;
    out_valid_o = out_valid_q;
    out_data_o  = out_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      pend_q      <= 1'b0;
      free_slot_q <= CntW'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      free_slot_q <= free_slot_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q      <= pix_d;
    addr_q     <= addr_d;
    pend_idx_q <= pend_idx_d;
    end_q      <= end_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

endmodule

`default_nettype wire

// File: design/pbq_checker.sv
// port-level checker for the palette builder, bound to the top level
`default_nettype none
`include "palette_builder_quantizer_core_macros.svh"

module pbq_checker
  import pbq_pkg::*;
(
  input wire logic    clk_i,
  input wire logic    rst_ni,
  input wire logic    in_valid_i,
  input wire logic    in_ready_o,
  input wire pixel_t  in_data_i,
  input wire logic    out_valid_o,
  input wire logic    out_ready_i,
  input wire result_t out_data_o
);

  logic in_req;
  logic out_req;

  assign in_req  = in_valid_i && in_ready_o;
  assign out_req = out_valid_o && out_ready_i;

  // a pending result holds until taken
  `PBQ_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
  // block is not ready in the cycle after taking a request
  `PBQ_ASSERT(a_busy_after_req, in_req |=> !in_ready_o)
  // a new colour and an overflow never come together
  `PBQ_ASSERT(a_add_xor_full, out_valid_o |-> !(out_data_o.added_entry && out_data_o.palette_full))
  // overflow always answers index zero
  `PBQ_ASSERT(a_full_index, out_valid_o && out_data_o.palette_full |->
              out_data_o.palette_index == 8'd0)
  // a new result only shows up while the block is busy with a request
  `PBQ_ASSERT(a_no_result_unasked, $rose(out_valid_o) |-> $past(!in_ready_o))

endmodule

bind palette_builder_quantizer_core pbq_checker u_pbq_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

`default_nettype wire

// File: test/tb_palette_builder_quantizer_core.sv
// self-checking testbench for the exact-match palette builder core
module tb_palette_builder_quantizer_core;
  import pbq_pkg::*;

  localparam int unsigned PaletteSize = PaletteSizeDef;
  localparam int unsigned StallLimit  = 20000;
  localparam int unsigned LongHold    = 1500;

  logic    clk_i       = 1'b0;
  logic    rst_ni      = 1'b0;
  logic    in_valid_i  = 1'b0;
  logic    in_ready_o;
  pixel_t  in_data_i   = '0;
  logic    out_valid_o;
  logic    out_ready_i = 1'b0;
  result_t out_data_o;

  palette_builder_quantizer_core #(
    .PaletteSize(PaletteSize)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // shadow copy of the colour table and the fill pointer
  logic [23:0] shadow_palette [PaletteSize];
  logic [8:0]  shadow_next_free = 9'd1;
  result_t     pending_results [$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_req       = 0;
  int unsigned error_count    = 0;
  int unsigned pixels_sent    = 0;
  int unsigned results_seen   = 0;
  int unsigned n_matched      = 0;
  int unsigned n_stored       = 0;
  int unsigned n_overflow     = 0;

  initial begin
    for (int k = 0; k < PaletteSize; k++) shadow_palette[k] = '0;
  end

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic result_t palette_lookup(pixel_t px);
    logic [23:0] colour;
    result_t     res;
    bit          hit;
    colour = {px.red, px.green, px.blue};
    res    = '0;
    hit    = 1'b0;
    // the top entry is never searched
    for (int k = 0; k <= PaletteSize - 2; k++) begin
      if (!hit && shadow_palette[k] == colour) begin
        res.palette_index = 8'(k);
        hit = 1'b1;
      end
    end
    if (hit) begin
      n_matched++;
    end else if (shadow_next_free < PaletteSize) begin
      shadow_palette[shadow_next_free[7:0]] = colour;
      res.palette_index = shadow_next_free[7:0];
      res.added_entry   = 1'b1;
      shadow_next_free  = shadow_next_free + 9'd1;
      n_stored++;
    end else begin
      res.palette_full = 1'b1;
      n_overflow++;
    end
    res.last_out = px.last_pixel;
    return res;
  endfunction

  function automatic bit colour_known(logic [23:0] colour);
    bit found;
    found = 1'b0;
    for (int k = 0; k < PaletteSize; k++) begin
      if (k < shadow_next_free && shadow_palette[k] == colour) found = 1'b1;
    end
    return found;
  endfunction

  function automatic pixel_t mk_pixel(logic [23:0] colour, logic last);
    pixel_t px;
    px.red        = colour[23:16];
    px.green      = colour[15:8];
    px.blue       = colour[7:0];
    px.last_pixel = last;
    return px;
  endfunction

  // mix of repeats of stored colours, black and fresh colours
  function automatic pixel_t random_pixel();
    int unsigned pick;
    int unsigned top;
    logic [23:0] colour;
    pick = $urandom_range(99);
    top  = (shadow_next_free > PaletteSize - 1) ? PaletteSize - 1 : shadow_next_free - 1;
    if (pick < 40) begin
      colour = shadow_palette[$urandom_range(top)];
    end else if (pick < 45) begin
      colour = '0;
    end else begin
      colour = 24'($urandom());
    end
    return mk_pixel(colour, $urandom_range(9) == 0);
  endfunction

  task automatic send_pixel(pixel_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= px;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(palette_lookup(px));
    pixels_sent++;
  endtask

  task automatic wait_results_done();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_random_pixels(int unsigned count);
    repeat (count) send_pixel(random_pixel());
    wait_results_done();
  endtask

  // receiver: random stalls, or a long hold-off when requested
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with no pending request: index %0d", out_data_o.palette_index);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.palette_index !== want.palette_index) begin
          $error("palette_index expected %0d actual %0d",
                 want.palette_index, out_data_o.palette_index);
          error_count++;
        end
        if (out_data_o.added_entry !== want.added_entry) begin
          $error("added_entry expected %0d actual %0d",
                 want.added_entry, out_data_o.added_entry);
          error_count++;
        end
        if (out_data_o.palette_full !== want.palette_full) begin
          $error("palette_full expected %0d actual %0d",
                 want.palette_full, out_data_o.palette_full);
          error_count++;
        end
        if (out_data_o.last_out !== want.last_out) begin
          $error("last_out expected %0d actual %0d", want.last_out, out_data_o.last_out);
          error_count++;
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("palette_builder_quantizer_core: mismatch");
    $finish;
  end

  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // black hits entry 0 straight after reset
    send_pixel(mk_pixel(24'h000000, 1'b0));
    send_pixel(mk_pixel(24'h000000, 1'b1));
    send_pixel(mk_pixel(24'hFFFFFF, 1'b0));
    send_pixel(mk_pixel(24'hFF0000, 1'b0));
    send_pixel(mk_pixel(24'h00FF00, 1'b1));
    send_pixel(mk_pixel(24'h0000FF, 1'b0));
    send_pixel(mk_pixel(24'hFFFFFF, 1'b1));
    send_pixel(mk_pixel(24'h000001, 1'b0));
    send_pixel(mk_pixel(24'h010000, 1'b0));
    send_pixel(mk_pixel(24'hAA55AA, 1'b0));
    send_pixel(mk_pixel(24'h55AA55, 1'b1));
    send_pixel(mk_pixel(24'hFF0000, 1'b0));
    send_pixel(mk_pixel(24'h000001, 1'b0));
    send_pixel(mk_pixel(24'h000000, 1'b1));
    wait_results_done();
  endtask

  task automatic test_no_idle();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random_pixels(170);
  endtask

  task automatic test_sender_idle();
    send_idle_pct  = 69;
    recv_stall_pct = 0;
    run_random_pixels(170);
  endtask

  task automatic test_receiver_stall();
    send_idle_pct  = 0;
    recv_stall_pct = 69;
    run_random_pixels(170);
  endtask

  task automatic test_both_idle();
    send_idle_pct  = 22;
    recv_stall_pct = 22;
    run_random_pixels(200);
  endtask

  // receiver holds off while the sender keeps offering requests
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = LongHold;
    repeat (20) send_pixel(random_pixel());
    wait_results_done();
  endtask

  // fill every free slot, then hit the unsearched top entry and overflow
  task automatic test_fill_to_overflow();
    logic [23:0] colour;
    send_idle_pct  = 22;
    recv_stall_pct = 22;
    while (shadow_next_free < PaletteSize) begin
      do colour = 24'($urandom()); while (colour_known(colour));
      send_pixel(mk_pixel(colour, $urandom_range(9) == 0));
    end
    send_pixel(mk_pixel(shadow_palette[PaletteSize - 1], 1'b0));
    send_pixel(mk_pixel(shadow_palette[PaletteSize - 2], 1'b1));
    send_pixel(mk_pixel(shadow_palette[1], 1'b0));
    send_pixel(mk_pixel(24'h000000, 1'b0));
    do colour = 24'($urandom()); while (colour_known(colour));
    send_pixel(mk_pixel(colour, 1'b1));
    send_pixel(mk_pixel(shadow_palette[PaletteSize - 1], 1'b1));
    wait_results_done();
  endtask

  task automatic test_after_full();
    send_idle_pct  = 22;
    recv_stall_pct = 22;
    run_random_pixels(40);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_no_idle();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    test_backpressure();
    test_fill_to_overflow();
    test_after_full();

    repeat (PaletteSize + 8) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      error_count++;
    end
    $display("%0d pixels over idle, stall, hold-off and fill phases, %0d results checked",
             pixels_sent, results_seen);
    $display("%0d matched, %0d stored, %0d overflowed the palette",
             n_matched, n_stored, n_overflow);
    if (error_count == 0) begin
      $display("palette_builder_quantizer_core: match");
    end else begin
      $display("palette_builder_quantizer_core: mismatch");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/pbq_pkg.sv
design/pbq_ram.sv
design/palette_builder_quantizer_core.sv
design/pbq_checker.sv
test/tb_palette_builder_quantizer_core.sv
